// ===== rtl/epa_pkg.sv =====
// Package for the even port allocator: table sizing, port and status widths,
// status and action codes, and divider sizing. No dependencies.
`timescale 1ns / 1ps
package epa_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int PORT_W   = 16;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 3;

	localparam logic [PORT_W-1:0] PORT_MAX = 16'hffff;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BOUND     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NONE_FREE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

	localparam logic ACT_ACQUIRE = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// Restoring divider: one quotient bit per cycle over the 32-bit dividend.
	localparam int DIV_STEPS = WORD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

// ===== rtl/even_port_allocator.sv =====
// Top level of the even port allocator: sequencer, port table and result register.
// Depends on epa_pkg and epa_mod_unit.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake         Payload
// --------  ---------  ----------------  ------------------------------------------
// command   in         start & !busy     action, range_start, range_end,
//                                        random_value, release_port
// result    out        done (one cycle)  port, status
//
// One transaction is taken at a time; busy stays high until its result is out.
// Acquire: a bounds check, the remainder unit (32 steps, then the remainder is
// handed over), then one table scan of up to TABLE_DEPTH entries per candidate
// port (a scan ends early on a hit), at most TABLE_DEPTH + 1 candidates, then a
// record step. Equal bounds skip the divider and scan and go straight to record;
// invalid bounds end at the bounds check.
// Release: a scan of up to TABLE_DEPTH entries, one entry a cycle on a single read port.
// Reset clears the valid bits and control; table contents stay undefined.
// The receiver cannot stall: done is a one-cycle strobe and a new start can be
// taken in the same cycle that done is high.
//
module even_port_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          action,
	input  logic [epa_pkg::WORD_W-1:0]    range_start,
	input  logic [epa_pkg::WORD_W-1:0]    range_end,
	input  logic [epa_pkg::WORD_W-1:0]    random_value,
	input  logic [epa_pkg::WORD_W-1:0]    release_port,
	output logic                          done,
	output logic [epa_pkg::PORT_W-1:0]    port,
	output logic [epa_pkg::STATUS_W-1:0]  status
);
	import epa_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_PROBE = 3'd2;
	localparam logic [2:0] S_REC   = 3'd3;
	localparam logic [2:0] S_REL   = 3'd4;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

	logic [2:0]             state_q;
	logic [IDX_W-1:0]       idx_q;
	logic [PORT_W-1:0]      lo_q;
	logic [PORT_W-1:0]      hi_q;
	logic [PORT_W-1:0]      first_q;
	logic [PORT_W-1:0]      cand_q;
	logic                   done_q;
	logic [PORT_W-1:0]      port_q;
	logic [STATUS_W-1:0]    status_q;

	logic [PORT_W-1:0]      tbl_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;

	// Table write and valid-bit controls from the sequencer
	logic                   tbl_wr;
	logic [IDX_W-1:0]       tbl_wr_idx;
	logic                   vld_clr;

	logic                   accept;
	logic                   bound_bad;
	logic [PORT_W-1:0]      lo_n;
	logic [PORT_W-1:0]      hi_n;
	logic                   div_go;
	logic                   div_done;
	logic [PORT_W-1:0]      div_rem;
	logic [PORT_W-1:0]      start_sum;
	logic [PORT_W-1:0]      first_even;
	logic [PORT_W-1:0]      even_lo;
	logic [PORT_W:0]        cand_step;
	logic [PORT_W-1:0]      cand_next;
	logic                   entry_hit;
	logic                   slot_found;
	logic [IDX_W-1:0]       slot_idx;

	assign accept    = start && (state_q == S_IDLE);
	assign bound_bad = (|range_start[WORD_W-1:PORT_W]) || (|range_end[WORD_W-1:PORT_W]);

	// Order the bounds; only the low half matters once the bound check passes.
	always_comb begin
		if (range_start[PORT_W-1:0] > range_end[PORT_W-1:0]) begin
			lo_n = range_end[PORT_W-1:0];
			hi_n = range_start[PORT_W-1:0];
		end else begin
			lo_n = range_start[PORT_W-1:0];
			hi_n = range_end[PORT_W-1:0];
		end
	end

	assign div_go = accept && (action == ACT_ACQUIRE) && !bound_bad && (lo_n != hi_n);

	epa_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.dividend  (random_value),
		.divisor   (hi_n - lo_n),
		.done      (div_done),
		.remainder (div_rem)
	);

	// Starting candidate: lo + remainder, rounded up to even (stays within hi).
	assign start_sum  = lo_q + div_rem;
	assign first_even = start_sum + {{(PORT_W-1){1'b0}}, start_sum[0]};
	assign even_lo    = lo_q + {{(PORT_W-1){1'b0}}, lo_q[0]};

	// Step past a used port; wrap to the first even port when beyond hi.
	assign cand_step = {1'b0, cand_q} + (PORT_W+1)'(2);
	assign cand_next = (cand_step > {1'b0, hi_q}) ? even_lo : cand_step[PORT_W-1:0];

	// Single table read port, addressed by the scan counter.
	assign entry_hit = valid_q[idx_q] && (tbl_q[idx_q] == cand_q);

	// Lowest free entry from the valid bits.
	always_comb begin
		slot_found = 1'b0;
		slot_idx   = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				slot_found = 1'b1;
				slot_idx   = IDX_W'(i);
			end
		end
	end

	assign tbl_wr     = (state_q == S_REC) && slot_found;
	assign tbl_wr_idx = slot_idx;
	assign vld_clr    = (state_q == S_REL) && entry_hit;

	always_ff @(posedge clk) begin
		if (tbl_wr) begin
			tbl_q[tbl_wr_idx] <= cand_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (tbl_wr) begin
				valid_q[tbl_wr_idx] <= 1'b1;
			end
			if (vld_clr) begin
				valid_q[idx_q] <= 1'b0;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						if (action == ACT_RELEASE) begin
							if (|release_port[WORD_W-1:PORT_W]) begin
								done_q <= 1'b1;
							end else begin
								state_q <= S_REL;
							end
						end else if (bound_bad) begin
							done_q <= 1'b1;
						end else if (lo_n == hi_n) begin
							state_q <= S_REC;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (entry_hit) begin
						idx_q <= '0;
						if (cand_next == first_q) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (idx_q == IDX_LAST) begin
						idx_q <= '0;
						if (cand_q == '0) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_REC;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_REC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_REL: begin
					if (entry_hit || (idx_q == IDX_LAST)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload: bounds, candidate and result register
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				lo_q     <= lo_n;
				hi_q     <= hi_n;
				cand_q   <= (action == ACT_RELEASE) ? release_port[PORT_W-1:0] : lo_n;
				port_q   <= '0;
				status_q <= (action == ACT_RELEASE) ? ST_NOT_FOUND : ST_BOUND;
			end
			S_DIV: begin
				first_q <= first_even;
				cand_q  <= first_even;
			end
			S_PROBE: begin
				port_q   <= '0;
				status_q <= ST_NONE_FREE;
				if (entry_hit) begin
					cand_q <= cand_next;
				end
			end
			S_REC: begin
				if (slot_found) begin
					port_q   <= cand_q;
					status_q <= ST_OK;
				end else begin
					port_q   <= '0;
					status_q <= ST_FULL;
				end
			end
			S_REL: begin
				port_q   <= '0;
				status_q <= entry_hit ? ST_OK : ST_NOT_FOUND;
			end
			default: begin
				port_q   <= '0;
				status_q <= ST_OK;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign port   = port_q;
	assign status = status_q;

endmodule

// ===== rtl/epa_mod_unit.sv =====
// Iterative remainder unit: 32-bit dividend modulo 16-bit divisor, one bit a cycle.
// Depends on epa_pkg.
`timescale 1ns / 1ps
module epa_mod_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [epa_pkg::WORD_W-1:0]  dividend,
	input  logic [epa_pkg::PORT_W-1:0]  divisor,
	output logic                        done,
	output logic [epa_pkg::PORT_W-1:0]  remainder
);
	import epa_pkg::*;

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [WORD_W-1:0]    dvd_q;
	logic [PORT_W-1:0]    dsr_q;
	logic [PORT_W-1:0]    rem_q;
	logic [PORT_W:0]      trial;
	logic                 fits;
	logic [PORT_W-1:0]    rem_next;

	// Shift in the next dividend bit and subtract when the divisor fits.
	always_comb begin
		trial    = {rem_q, dvd_q[WORD_W-1]};
		fits     = (trial >= {1'b0, dsr_q});
		rem_next = fits ? PORT_W'(trial - {1'b0, dsr_q}) : trial[PORT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== dv/epa_checker.sv =====
// Checker for the even port allocator: tracks the port table, predicts each
// result and compares it with what the block returns. Depends on epa_pkg.
`timescale 1ns / 1ps
module epa_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          action,
	input  logic [epa_pkg::WORD_W-1:0]    range_start,
	input  logic [epa_pkg::WORD_W-1:0]    range_end,
	input  logic [epa_pkg::WORD_W-1:0]    random_value,
	input  logic [epa_pkg::WORD_W-1:0]    release_port,
	input  logic                          done,
	input  logic [epa_pkg::PORT_W-1:0]    port,
	input  logic [epa_pkg::STATUS_W-1:0]  status,
	output int                            mismatches,
	output int                            outstanding
);
	import epa_pkg::*;

	typedef struct packed {
		logic [PORT_W-1:0]   port;
		logic [STATUS_W-1:0] status;
	} alloc_result_t;

	logic [PORT_W-1:0] tbl_port [TABLE_DEPTH];
	logic              tbl_valid[TABLE_DEPTH];
	alloc_result_t     due_results[$];

	function automatic bit port_listed(input logic [WORD_W-1:0] p);
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (tbl_valid[i] && {{(WORD_W-PORT_W){1'b0}}, tbl_port[i]} == p)
				return 1'b1;
		return 1'b0;
	endfunction

	// Take the lowest free entry; report failure when none is free.
	function automatic bit claim_entry(input logic [PORT_W-1:0] p);
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (!tbl_valid[i]) begin
				tbl_port[i]  = p;
				tbl_valid[i] = 1'b1;
				return 1'b1;
			end
		return 1'b0;
	endfunction

	function automatic alloc_result_t acquire_port(input logic [WORD_W-1:0] lo,
			input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] rnd);
		logic [WORD_W-1:0] first, cand, even_lo, swap;
		alloc_result_t     res;
		res.port = '0;
		if (lo > PORT_MAX || hi > PORT_MAX) begin
			res.status = ST_BOUND;
			return res;
		end
		if (lo > hi) begin
			swap = lo;
			lo   = hi;
			hi   = swap;
		end else if (lo == hi) begin
			if (!claim_entry(lo[PORT_W-1:0])) begin
				res.status = ST_FULL;
			end else begin
				res.port   = lo[PORT_W-1:0];
				res.status = ST_OK;
			end
			return res;
		end
		first = lo + (rnd % (hi - lo));
		if (first[0])
			first = first + 1;
		even_lo = lo + lo[0];
		cand    = first;
		while (port_listed(cand)) begin
			cand = cand + 2;
			if (cand > hi)
				cand = even_lo;
			if (cand == first) begin
				res.status = ST_NONE_FREE;
				return res;
			end
		end
		// Port 0 is never handed out by a search.
		if (cand == '0) begin
			res.status = ST_NONE_FREE;
			return res;
		end
		if (!claim_entry(cand[PORT_W-1:0])) begin
			res.status = ST_FULL;
			return res;
		end
		res.port   = cand[PORT_W-1:0];
		res.status = ST_OK;
		return res;
	endfunction

	function automatic alloc_result_t release_entry(input logic [WORD_W-1:0] p);
		alloc_result_t res;
		res.port   = '0;
		res.status = ST_NOT_FOUND;
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (tbl_valid[i] && {{(WORD_W-PORT_W){1'b0}}, tbl_port[i]} == p) begin
				tbl_valid[i] = 1'b0;
				res.status   = ST_OK;
				return res;
			end
		return res;
	endfunction

	task automatic flag(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%t mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t due;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				tbl_valid[i] = 1'b0;
			due_results.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			// Retire the result first, so one arriving with a new transaction
			// is matched against the older expectation.
			if (done) begin
				if (due_results.size() == 0) begin
					flag($sformatf("result port %0d status %0d with nothing outstanding",
						port, status));
				end else begin
					due = due_results.pop_front();
					if (port !== due.port)
						flag($sformatf("port expected %0d got %0d", due.port, port));
					if (status !== due.status)
						flag($sformatf("status expected %0d got %0d", due.status, status));
				end
			end
			if (start && !busy) begin
				if (action == ACT_ACQUIRE)
					due_results.push_back(acquire_port(range_start, range_end, random_value));
				else
					due_results.push_back(release_entry(release_port));
			end
			outstanding = due_results.size();
		end
	end

endmodule

// ===== dv/even_port_allocator_tb.sv =====
// Testbench top for the even port allocator: clock, reset, command stimulus
// and verdict. Depends on epa_pkg, even_port_allocator and epa_checker.
`timescale 1ns / 1ps
module even_port_allocator_tb;
	import epa_pkg::*;

	// Generous bound: every acquire at its slowest (bounds check, divider,
	// TABLE_DEPTH + 1 full scans, record) plus the longest sender gap,
	// for about 470 transactions, taken several times over.
	localparam int LIMIT_CYCLES = 3_000_000;

	logic                clk    = 1'b0;
	logic                arst_n = 1'b0;
	logic                start  = 1'b0;
	logic                action = ACT_ACQUIRE;
	logic [WORD_W-1:0]   range_start  = '0;
	logic [WORD_W-1:0]   range_end    = '0;
	logic [WORD_W-1:0]   random_value = '0;
	logic [WORD_W-1:0]   release_port = '0;
	logic                busy;
	logic                done;
	logic [PORT_W-1:0]   port;
	logic [STATUS_W-1:0] status;

	int          mismatches;
	int          outstanding;
	int          idle_pct = 0;
	int unsigned cycles   = 0;

	// Small windows of ports keep the table crowded so that collisions,
	// wrap-around, exhaustion and a full table all turn up often. One window
	// starts at 0 (port 0 handling), one on an odd bound, one ends at 65535.
	int unsigned win_base[4] = '{0, 1, 1000, 65511};

	always #10 clk = ~clk;

	even_port_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.range_start  (range_start),
		.range_end    (range_end),
		.random_value (random_value),
		.release_port (release_port),
		.done         (done),
		.port         (port),
		.status       (status)
	);

	epa_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.range_start  (range_start),
		.range_end    (range_end),
		.random_value (random_value),
		.release_port (release_port),
		.done         (done),
		.port         (port),
		.status       (status),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Watchdog: drop the run if it hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("FAIL even_port_allocator");
			$finish;
		end
	end

	// Present one transaction and hold it until the block takes it. Called at
	// a rising edge; returns at the edge that accepted the transaction, so a
	// following call either drops start for a gap or keeps it high with new
	// payload, never both in one step.
	task automatic issue(input logic act, input logic [WORD_W-1:0] lo,
			input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] rnd,
			input logic [WORD_W-1:0] rel);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		action       <= act;
		range_start  <= lo;
		range_end    <= hi;
		random_value <= rnd;
		release_port <= rel;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Unused fields carry random noise so that they are seen to be ignored.
	task automatic request_port(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
			input logic [WORD_W-1:0] rnd);
		issue(ACT_ACQUIRE, lo, hi, rnd, $urandom);
	endtask

	task automatic return_port(input logic [WORD_W-1:0] rel);
		issue(ACT_RELEASE, $urandom, $urandom, $urandom, rel);
	endtask

	// One random transaction; acquire_pct sets the mix, so a run of calls
	// either fills the table or drains it.
	task automatic random_item(input int acquire_pct);
		logic [WORD_W-1:0] lo, hi, bad, other;
		int unsigned       base, kind;
		kind = $urandom_range(99);
		base = win_base[$urandom_range(3)];
		if ($urandom_range(99) < acquire_pct) begin
			if (kind < 8) begin
				// Out-of-range bound: force some bit above 15 on.
				bad   = $urandom | (32'd1 << $urandom_range(31, 16));
				other = ($urandom_range(3) == 0) ? $urandom : $urandom_range(65535, 0);
				if ($urandom_range(1))
					request_port(bad, other, $urandom);
				else
					request_port(other, bad, $urandom);
			end else if (kind < 20) begin
				// Equal bounds: recorded as is, duplicates included.
				lo = base + $urandom_range(24, 0);
				request_port(lo, lo, $urandom);
			end else if (kind < 30) begin
				request_port($urandom_range(65535, 0), $urandom_range(65535, 0), $urandom);
			end else begin
				lo = base;
				hi = base + $urandom_range(24, 1);
				if ($urandom_range(99) < 30)
					request_port(hi, lo, $urandom);
				else
					request_port(lo, hi, $urandom);
			end
		end else begin
			if (kind < 75)
				return_port(base + $urandom_range(24, 0));
			else if (kind < 90)
				return_port($urandom_range(65535, 0));
			else
				return_port($urandom);
		end
	endtask

	initial begin
		int pct_per_phase[4];
		pct_per_phase = '{0, 73, 30, 0};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: bound checks, port 0 handling, reversed bounds, wrap,
		// exhaustion, duplicates and releases that miss.
		request_port(32'h0001_0000, 32'd5, 32'd0);
		request_port(32'd5, 32'hffff_ffff, 32'hffff_ffff);
		return_port(32'hffff_ffff);
		request_port(32'd0, 32'd0, 32'd7);                   // equal bounds take port 0
		return_port(32'd0);
		request_port(32'd0, 32'd1, 32'd0);                   // search lands on port 0
		request_port(32'd65535, 32'd65534, 32'hffff_ffff);   // reversed, top of range
		request_port(32'd65534, 32'd65535, 32'd0);           // nothing free, wraps home
		request_port(32'd65535, 32'd65535, 32'd0);
		request_port(32'd0, 32'd65535, 32'hffff_ffff);       // start candidate is port 0
		request_port(32'd0, 32'd65535, 32'd65533);           // wraps round to port 0
		request_port(32'd3, 32'd9, 32'd5);                   // start 3 + 5 = 8 is already even
		request_port(32'd3, 32'd9, 32'd5);                   // 8 taken, wraps to 4
		request_port(32'd3, 32'd9, 32'd0);
		request_port(32'd3, 32'd9, 32'd0);                   // every even port taken
		return_port(32'd6);
		return_port(32'd6);                                  // already gone
		request_port(32'd8, 32'd8, 32'h8000_0000);           // duplicate entry
		return_port(32'd8);
		return_port(32'd8);
		return_port(32'd8);
		request_port(32'hffff_ffff, 32'hffff_ffff, 32'h5555_5555);

		// Random: four idling phases, each alternating fill and drain rounds
		// so that the table swings between full and nearly empty.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = pct_per_phase[ph];
			for (int rd = 0; rd < 4; rd++)
				repeat (28) random_item((rd % 2 == 0) ? 90 : 25);
		end
		start <= 1'b0;

		// Wait for every outstanding result; the watchdog catches a hang.
		while (outstanding != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("PASS even_port_allocator");
		else
			$display("FAIL even_port_allocator");
		$finish;
	end

endmodule

// ===== even_port_allocator.f =====
rtl/epa_pkg.sv
rtl/epa_mod_unit.sv
rtl/even_port_allocator.sv
dv/epa_checker.sv
dv/even_port_allocator_tb.sv
